// ===== rtl/mgmt_pkg.sv =====
// Shared types and constants for the multicast group membership table.
`timescale 1ns / 1ps
`default_nettype none
package mgmt_pkg;
  localparam int MacW = 48;
  localparam int IpW = 32;
  localparam int MaxResults = 16;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_JOIN = 3'd1, FN_LEAVE = 3'd2, FN_LOOKUP = 3'd3, FN_LEAVE_ALL = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_PRESENT = 3'd1, ST_NOT_FOUND = 3'd2, ST_FULL = 3'd3, ST_EMPTY = 3'd4
  } status_t;

  localparam logic [23:0] McastPrefix = 24'h01005e;

  // classified command from front end to engine
  typedef struct packed {
    logic [2:0]      func;
    logic            known;
    logic [IpW-1:0]  group_ip;
    logic [MacW-1:0] station_mac;
    logic [MacW-1:0] lookup_mac;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_DONE, S_RD, S_RDW, S_CHK, S_SHIFT_RD, S_SHIFT_WR,
    S_DEL, S_LIST_RD, S_LIST_W, S_LIST_OUT, S_EMIT, S_NEXT_SLOT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/mgmt_front.sv =====
// Front end: accepts commands, classifies the function code, and queues them.
`timescale 1ns / 1ps
`default_nettype none
module mgmt_front
  import mgmt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [2:0] in_func,
  input  wire logic [IpW-1:0] in_ip,
  input  wire logic [MacW-1:0] in_sta,
  input  wire logic [MacW-1:0] in_lmac,
  output logic      cmd_valid,
  input  wire logic cmd_ready,
  output cmd_t      cmd
);
  cmd_t q [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop, known;

  always_comb begin
    unique case (in_func) inside
      FN_ADD, FN_JOIN, FN_LEAVE, FN_LOOKUP, FN_LEAVE_ALL: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_ready  = (cnt != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= '{func: in_func, known: known, group_ip: in_ip,
                         station_mac: in_sta, lookup_mac: in_lmac};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mgmt_engine.sv =====
// Back end: walks slots and receiver memory with one comparator per step.
`timescale 1ns / 1ps
`default_nettype none
module mgmt_engine
  import mgmt_pkg::*;
#(
  parameter int GROUP_SLOTS = 16,
  parameter int RECEIVERS_PER_GROUP = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output logic [2:0] res_status,
  output logic [MacW-1:0] res_mac,
  output logic      res_last
);
  localparam int SW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int RW = (RECEIVERS_PER_GROUP > 1) ? $clog2(RECEIVERS_PER_GROUP) : 1;
  localparam int CW = $clog2(RECEIVERS_PER_GROUP + 1);
  localparam int AW = SW + RW;
  localparam int MD = GROUP_SLOTS * RECEIVERS_PER_GROUP;
  localparam int NLim = (RECEIVERS_PER_GROUP < MaxResults) ? RECEIVERS_PER_GROUP
                                                           : MaxResults;

  logic [GROUP_SLOTS-1:0] valid;
  logic [IpW-1:0]  gip  [GROUP_SLOTS];
  logic [SW-1:0]   age  [GROUP_SLOTS];
  logic [CW-1:0]   rcnt [GROUP_SLOTS];
  logic [MacW-1:0] mem  [MD];
  logic [MacW-1:0] rd;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [MacW-1:0] wr_data;

  state_t state, state_next;
  cmd_t   c;
  logic [SW-1:0] si, best;
  logic          found, free_found;
  logic [SW-1:0] free_slot;
  logic [SW:0]   used;
  logic [RW-1:0] k;
  logic          hit;
  logic          more, list_end, out_free;
  logic          last_slot;

  assign last_slot = (si == SW'(GROUP_SLOTS - 1));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  logic [MacW-1:0] slot_mac;
  assign slot_mac = {McastPrefix, 1'b0, gip[si][22:0]};
  logic [AW-1:0] base;
  assign base = AW'(si) * AW'(RECEIVERS_PER_GROUP);

  assign hit      = (rcnt[si] != '0) && (rd == c.station_mac);
  assign more     = (CW'(k) + 1'b1) < rcnt[si];
  assign list_end = (CW'(k) + 1'b1 >= rcnt[si]) || (CW'(k) + 1'b1 >= CW'(NLim));
  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    rd_addr = base + AW'(k);
    wr_addr = base + AW'(k);
    wr_en = 1'b0;
    wr_data = rd;
    cmd_ready = (state == S_IDLE) && !res_valid;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          if (!cmd.known) state_next = S_IDLE;
          else if (cmd.func == FN_LEAVE_ALL) state_next = S_NEXT_SLOT;
          else state_next = S_SCAN;
        end
      end
      S_SCAN: if (last_slot) state_next = S_SCAN_DONE;
      S_SCAN_DONE: begin
        state_next = S_IDLE;
        if (c.func == FN_LOOKUP) begin
          if (found && rcnt[best] != '0) state_next = S_LIST_RD;
        end else if (c.func != FN_ADD && found) state_next = S_RD;
      end
      S_RD: state_next = (rcnt[si] == '0) ? S_CHK : S_RDW;
      S_RDW: state_next = S_CHK;
      S_CHK: begin
        if (hit) begin
          if (c.func == FN_JOIN) state_next = S_IDLE;
          else if (more) state_next = S_SHIFT_RD;
          else state_next = S_DEL;
        end else if (more) state_next = S_RD;
        else if (c.func == FN_JOIN)
          state_next = (rcnt[si] >= CW'(RECEIVERS_PER_GROUP)) ? S_IDLE : S_EMIT;
        else if (c.func == FN_LEAVE || last_slot) state_next = S_IDLE;
        else state_next = S_NEXT_SLOT;
      end
      S_SHIFT_RD: state_next = (CW'(k) < rcnt[si]) ? S_SHIFT_WR : S_DEL;
      S_SHIFT_WR: begin
        wr_en = 1'b1;
        wr_addr = base + AW'(k) - AW'(1);
        state_next = (k == RW'(RECEIVERS_PER_GROUP - 1)) ? S_DEL : S_SHIFT_RD;
      end
      S_DEL: state_next = (c.func == FN_LEAVE || last_slot) ? S_IDLE : S_NEXT_SLOT;
      S_NEXT_SLOT: begin
        if (valid[si] && rcnt[si] != '0) state_next = S_RD;
        else if (last_slot) state_next = S_IDLE;
      end
      // join append goes into the first free entry of the list
      S_EMIT: begin
        wr_en = 1'b1;
        wr_data = c.station_mac;
        state_next = S_IDLE;
      end
      S_LIST_RD: state_next = S_LIST_W;
      S_LIST_W: state_next = S_LIST_OUT;
      S_LIST_OUT: if (out_free) state_next = list_end ? S_IDLE : S_LIST_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer: all decisions and slot updates
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < GROUP_SLOTS; i++) rcnt[i] <= '0;
    end else begin
      // while listing, the next receiver replaces the one taken
      if (res_valid && res_ready && state != S_LIST_OUT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          c <= cmd; si <= '0; found <= 1'b0; free_found <= 1'b0; used <= '0; k <= '0;
          if (!cmd.known) begin
            res_valid <= 1'b1; res_status <= ST_NOT_FOUND; res_mac <= '0;
            res_last <= 1'b1;
          end
        end
        S_SCAN: begin
          if (valid[si]) begin
            used <= used + 1'b1;
            if (c.func == FN_LOOKUP) begin
              if (slot_mac == c.lookup_mac && (!found || age[si] < age[best])) begin
                found <= 1'b1; best <= si;
              end
            end else if (gip[si] == c.group_ip && !found) begin
              found <= 1'b1; best <= si;
            end
          end else if (!free_found) begin
            free_found <= 1'b1; free_slot <= si;
          end
          if (!last_slot) si <= si + 1'b1;
        end
        S_SCAN_DONE: begin
          res_mac <= '0; res_last <= 1'b1;
          unique case (c.func)
            FN_ADD: begin
              res_valid <= 1'b1;
              if (found) res_status <= ST_PRESENT;
              else if (!free_found) res_status <= ST_FULL;
              else begin
                valid[free_slot] <= 1'b1; gip[free_slot] <= c.group_ip;
                age[free_slot] <= SW'(used); rcnt[free_slot] <= '0;
                res_status <= ST_OK;
              end
            end
            FN_LOOKUP: begin
              if (!found) begin res_valid <= 1'b1; res_status <= ST_NOT_FOUND; end
              else if (rcnt[best] == '0) begin
                res_valid <= 1'b1; res_status <= ST_EMPTY;
              end else begin
                si <= best; k <= '0;
              end
            end
            default: begin
              if (!found) begin res_valid <= 1'b1; res_status <= ST_NOT_FOUND; end
              else begin si <= best; k <= '0; end
            end
          endcase
        end
        // search the receiver list of slot si for the station
        S_CHK: begin
          if (hit) begin
            if (c.func == FN_JOIN) begin
              res_valid <= 1'b1; res_status <= ST_PRESENT;
              res_mac <= '0; res_last <= 1'b1;
            end else if (more) begin
              k <= k + 1'b1;
            end
          end else if (more) begin
            k <= k + 1'b1;
          end else if (c.func == FN_JOIN) begin
            res_mac <= '0; res_last <= 1'b1;
            if (rcnt[si] >= CW'(RECEIVERS_PER_GROUP)) begin
              res_valid <= 1'b1; res_status <= ST_FULL;
            end else begin
              k <= RW'(rcnt[si]);
            end
          end else if (c.func == FN_LEAVE) begin
            res_valid <= 1'b1; res_status <= ST_NOT_FOUND;
            res_mac <= '0; res_last <= 1'b1;
          end else begin
            si <= si + 1'b1; k <= '0;
            if (last_slot) begin
              res_valid <= 1'b1; res_status <= ST_OK; res_mac <= '0;
              res_last <= 1'b1;
            end
          end
        end
        // move later receivers up by one: k points one past the hole
        S_SHIFT_WR: k <= k + 1'b1;
        S_DEL: begin
          rcnt[si] <= rcnt[si] - 1'b1;
          if (rcnt[si] == CW'(1)) begin
            valid[si] <= 1'b0;
            for (int t = 0; t < GROUP_SLOTS; t++)
              if (valid[t] && SW'(t) != si && age[t] > age[si]) age[t] <= age[t] - 1'b1;
          end
          if (c.func == FN_LEAVE || last_slot) begin
            res_valid <= 1'b1; res_status <= ST_OK; res_mac <= '0;
            res_last <= 1'b1;
          end else begin
            si <= si + 1'b1; k <= '0;
          end
        end
        S_NEXT_SLOT: begin
          k <= '0;
          if (!(valid[si] && rcnt[si] != '0)) begin
            if (last_slot) begin
              res_valid <= 1'b1; res_status <= ST_OK; res_mac <= '0;
              res_last <= 1'b1;
            end else si <= si + 1'b1;
          end
        end
        S_EMIT: begin
          rcnt[si] <= rcnt[si] + 1'b1;
          res_valid <= 1'b1; res_status <= ST_OK;
        end
        S_LIST_OUT: if (out_free) begin
          res_valid <= 1'b1; res_status <= ST_OK; res_mac <= rd;
          res_last <= list_end;
          if (!list_end) k <= k + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/multicast_group_membership_table_core.sv =====
// Top level of the multicast group membership table.
//  channel | dir | tdata (low bit up)                               | tuser
//  s_axis  | in  | func[2:0] group_ip[34:3] station_mac lookup_mac  | -
//  m_axis  | out | status[2:0] receiver_mac[50:3], zero padded      | -, tlast = last
// Add, join, leave and lookup first scan the slots (one slot per cycle), then
// read each receiver to compare or list it; a join then appends the station, and
// a leave moves each later receiver up (a read, then a write) and updates the count.
// Leave all skips the scan and visits the slots in turn, with the same receiver steps.
// Reset is synchronous and empties the table at once. A two-entry queue lets new
// items arrive while one runs; the engine takes the next one only once its result left.
`timescale 1ns / 1ps
`default_nettype none
module multicast_group_membership_table_core
  import mgmt_pkg::*;
#(
  parameter int GROUP_SLOTS = 16,
  parameter int RECEIVERS_PER_GROUP = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [135:0] s_axis_tdata, // func, group_ip, station_mac, lookup_mac
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [55:0] m_axis_tdata,       // status, receiver_mac
  output logic      m_axis_tlast
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  logic [2:0] st;
  logic [MacW-1:0] mac;

  mgmt_front u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_func(s_axis_tdata[2:0]), .in_ip(s_axis_tdata[34:3]),
    .in_sta(s_axis_tdata[82:35]), .in_lmac(s_axis_tdata[130:83]),
    .cmd_valid, .cmd_ready, .cmd
  );

  mgmt_engine #(.GROUP_SLOTS(GROUP_SLOTS), .RECEIVERS_PER_GROUP(RECEIVERS_PER_GROUP))
  u_engine (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
    .res_status(st), .res_mac(mac), .res_last(m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, mac, st};

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_mac0: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st != ST_OK |-> mac == '0) else $error("mac not zero");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/tb_multicast_group_membership_table_core.sv =====
// Testbench for the multicast group membership table: random and directed items, scoreboarded.
`timescale 1ns / 1ps
`default_nettype none

// Table predictor plus queue of expected output items.
class group_table_scoreboard;
  localparam int Slots = 16;
  localparam int Rcv = 16;

  bit               valid_q [Slots];
  logic [31:0]      ip_q    [Slots];
  logic [47:0]      mac_q   [Slots];
  int unsigned      age_q   [Slots];
  int unsigned      cnt_q   [Slots];
  logic [47:0]      rcv_q   [Slots][Rcv];

  logic [51:0]      expected_q[$];   // {last, status, receiver_mac}
  int               errors;
  int               checked;

  function void clear();
    foreach (valid_q[s]) begin
      valid_q[s] = 0;
      cnt_q[s] = 0;
    end
    expected_q.delete();
    errors = 0;
    checked = 0;
  endfunction

  function int find_group(logic [31:0] ip);
    for (int s = 0; s < Slots; s++)
      if (valid_q[s] && ip_q[s] == ip) return s;
    return -1;
  endfunction

  function int find_member(int s, logic [47:0] m);
    for (int k = 0; k < cnt_q[s]; k++)
      if (rcv_q[s][k] == m) return k;
    return -1;
  endfunction

  function void drop_member(int s, int k);
    for (int j = k; j + 1 < cnt_q[s]; j++) rcv_q[s][j] = rcv_q[s][j+1];
    cnt_q[s]--;
    if (cnt_q[s] == 0) begin
      for (int t = 0; t < Slots; t++)
        if (valid_q[t] && t != s && age_q[t] > age_q[s]) age_q[t]--;
      valid_q[s] = 0;
    end
  endfunction

  function void push(mgmt_pkg::status_t st, logic [47:0] m, bit last);
    expected_q.insert(expected_q.size(), {last, st, m});
  endfunction

  // Note an accepted input item and queue its results.
  function void note_command(logic [2:0] fn, logic [31:0] ip, logic [47:0] sta,
                             logic [47:0] lmac);
    mgmt_pkg::status_t st;
    int s, k, best, used, free_s;
    st = mgmt_pkg::ST_NOT_FOUND;
    case (fn)
      mgmt_pkg::FN_ADD: begin
        if (find_group(ip) >= 0) st = mgmt_pkg::ST_PRESENT;
        else begin
          used = 0;
          free_s = -1;
          for (s = 0; s < Slots; s++)
            if (valid_q[s]) used++;
            else if (free_s < 0) free_s = s;
          if (free_s < 0) st = mgmt_pkg::ST_FULL;
          else begin
            valid_q[free_s] = 1;
            ip_q[free_s] = ip;
            mac_q[free_s] = {mgmt_pkg::McastPrefix, 1'b0, ip[22:0]};
            age_q[free_s] = used;
            cnt_q[free_s] = 0;
            st = mgmt_pkg::ST_OK;
          end
        end
      end
      mgmt_pkg::FN_JOIN: begin
        s = find_group(ip);
        if (s < 0) st = mgmt_pkg::ST_NOT_FOUND;
        else if (find_member(s, sta) >= 0) st = mgmt_pkg::ST_PRESENT;
        else if (cnt_q[s] >= Rcv) st = mgmt_pkg::ST_FULL;
        else begin
          rcv_q[s][cnt_q[s]] = sta;
          cnt_q[s]++;
          st = mgmt_pkg::ST_OK;
        end
      end
      mgmt_pkg::FN_LEAVE: begin
        s = find_group(ip);
        k = (s < 0) ? -1 : find_member(s, sta);
        if (k >= 0) begin
          drop_member(s, k);
          st = mgmt_pkg::ST_OK;
        end
      end
      mgmt_pkg::FN_LOOKUP: begin
        best = -1;
        for (s = 0; s < Slots; s++)
          if (valid_q[s] && mac_q[s] == lmac && (best < 0 || age_q[s] < age_q[best]))
            best = s;
        if (best >= 0 && cnt_q[best] == 0) st = mgmt_pkg::ST_EMPTY;
        else if (best >= 0) begin
          for (int j = 0; j < cnt_q[best]; j++)
            push(mgmt_pkg::ST_OK, rcv_q[best][j], j + 1 == cnt_q[best]);
          return;
        end
      end
      mgmt_pkg::FN_LEAVE_ALL: begin
        for (s = 0; s < Slots; s++)
          if (valid_q[s]) begin
            k = find_member(s, sta);
            if (k >= 0) drop_member(s, k);
          end
        st = mgmt_pkg::ST_OK;
      end
      default: ;
    endcase
    push(st, '0, 1'b1);
  endfunction

  // Compare one accepted output item with the oldest expectation.
  function void check_result(logic [55:0] data, logic last);
    logic [51:0] e;
    checked++;
    if (expected_q.size() == 0) begin
      $error("unexpected output item: status %0d mac %h", data[2:0], data[50:3]);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (data[2:0] !== e[50:48]) begin
      $error("status: expected %0d actual %0d", e[50:48], data[2:0]);
      errors++;
    end
    if (data[50:3] !== e[47:0]) begin
      $error("receiver_mac: expected %h actual %h", e[47:0], data[50:3]);
      errors++;
    end
    if (last !== e[51]) begin
      $error("last: expected %0b actual %0b", e[51], last);
      errors++;
    end
    if (data[55:51] !== 5'd0) begin
      $error("tdata pad: expected 0 actual %h", data[55:51]);
      errors++;
    end
  endfunction
endclass

module tb_multicast_group_membership_table_core;
  import mgmt_pkg::*;

  localparam int Limit = 2_000_000;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [55:0]  m_axis_tdata;
  logic         m_axis_tlast;

  group_table_scoreboard sb;
  bit          src_idle_on = 1;   // random gaps on the input side
  bit          sink_idle_on = 1;  // random stalls on the output side
  bit          sink_hold = 0;     // long receiver hold-off request
  int          cycles = 0;
  int          items_sent = 0;
  logic [31:0] known_ips [$];     // group addresses used so far
  logic [47:0] stations [8];      // small station pool so joins and leaves collide

  multicast_group_membership_table_core u_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Output side: sample the handshake, then pick the next tready.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
    if (sink_hold && hold_left == 0) begin
      hold_left = 600;
      sink_hold = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 0;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready <= 0;
    end else
      m_axis_tready <= 1;
  end

  // Offer one item and wait for it to be taken; idle gaps come before it.
  task automatic send_item(logic [2:0] fn, logic [31:0] ip, logic [47:0] sta,
                           logic [47:0] lmac);
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'd0, lmac, sta, ip, fn};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(fn, ip, sta, lmac);
    items_sent++;
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  // Wait until every expected output item has come out.
  task automatic drain();
    go_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [47:0] group_mac(logic [31:0] ip);
    return {McastPrefix, 1'b0, ip[22:0]};
  endfunction

  function automatic logic [31:0] pick_ip();
    if (known_ips.size() != 0 && $urandom_range(0, 9) != 0)
      return known_ips[$urandom_range(0, known_ips.size() - 1)];
    return {24'he00000, 8'($urandom_range(0, 15))};
  endfunction

  // Random item, weighted toward operations on known groups and stations.
  task automatic random_item();
    int r;
    logic [31:0] ip;
    logic [47:0] sta;
    logic [2:0]  fn;
    r = $urandom_range(0, 99);
    ip = pick_ip();
    sta = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom})
                                      : stations[$urandom_range(0, 7)];
    if (r < 15) begin
      fn = FN_ADD;
      if ($urandom_range(0, 3) == 0) ip = $urandom;
      known_ips.insert(known_ips.size(), ip);
    end else if (r < 50) fn = FN_JOIN;
    else if (r < 65) fn = FN_LEAVE;
    else if (r < 85) fn = FN_LOOKUP;
    else if (r < 93) fn = FN_LEAVE_ALL;
    else fn = 3'($urandom_range(5, 7));
    send_item(fn, ip, sta,
              ($urandom_range(0, 5) == 0) ? 48'({$urandom, $urandom}) : group_mac(ip));
  endtask

  initial begin
    logic [31:0] ip;
    sb = new();
    sb.clear();
    foreach (stations[i]) stations[i] = 48'({$urandom, $urandom});
    stations[0] = 48'h0;
    stations[1] = 48'hffff_ffff_ffff;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty table, extremes, full list, full table, aliasing MACs.
    send_item(FN_LOOKUP, 0, 0, group_mac(32'he000_0001));
    send_item(FN_JOIN, 32'he000_0001, stations[2], 0);
    send_item(FN_LEAVE, 32'he000_0001, stations[2], 0);
    send_item(FN_ADD, 32'hffff_ffff, 0, 0);
    send_item(FN_ADD, 32'hffff_ffff, 0, 0);
    send_item(FN_LOOKUP, 0, 0, group_mac(32'hffff_ffff));
    send_item(FN_ADD, 32'h0000_0000, 0, 0);
    send_item(FN_ADD, 32'h7f7f_ffff, 0, 0);  // same MAC as all-ones address
    send_item(FN_JOIN, 32'h7f7f_ffff, stations[1], 0);
    send_item(FN_LOOKUP, 0, 0, group_mac(32'hffff_ffff));  // oldest empty group wins
    for (int i = 0; i < 17; i++)
      send_item(FN_JOIN, 32'h0, (i == 16) ? 48'h0 : 48'h0000_1000 + i, 0);
    send_item(FN_JOIN, 32'h0, 48'h0000_1000, 0);
    send_item(FN_LOOKUP, 0, 0, group_mac(32'h0));
    send_item(FN_LEAVE, 32'h0, 48'h0000_1005, 0);
    send_item(FN_LEAVE_ALL, 0, stations[1], 0);    // deletes 7f7f_ffff group
    send_item(FN_LEAVE_ALL, 0, 48'hdead_beef, 0);
    send_item(3'd7, 32'hffff_ffff, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);

    // Fill the table and overflow it.
    for (int i = 0; i < 15; i++) send_item(FN_ADD, 32'he100_0000 + i, 0, 0);
    send_item(FN_ADD, 32'he200_0000, 0, 0);
    // Sender pause: let everything drain.
    drain();
    for (int i = 0; i < 16; i++) begin
      ip = (i == 0) ? 32'hffff_ffff : (i == 1) ? 32'h0 : 32'he100_0000 + i - 2;
      send_item(FN_JOIN, ip, stations[3], 0);
    end
    send_item(FN_LEAVE_ALL, 0, stations[3], 0);  // empties and deletes every group but group 0
    send_item(FN_LEAVE_ALL, 0, 48'h0000_1000, 0);
    drain();
    for (int i = 0; i < 16; i++) sb.valid_q[i] = sb.valid_q[i];  // state carries over

    // Long receiver hold-off while the sender keeps offering items.
    for (int i = 0; i < 4; i++) known_ips.insert(known_ips.size(), 32'he000_0010 + i);
    sink_hold = 1;
    for (int i = 0; i < 40; i++) random_item();

    // Random body with idling, then a quiet tail with none.
    for (int i = 0; i < 330; i++) begin
      if (i == 280) begin
        src_idle_on = 0;
        sink_idle_on = 0;
      end
      if (i % 60 == 59 && known_ips.size() > 40) known_ips.delete();
      random_item();
    end
    drain();

    $display("summary: %0d input items, %0d output items checked", items_sent, sb.checked);
    $display("covered all operations, full table and list, lookups of up to 16 receivers");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/mgmt_pkg.sv
rtl/mgmt_front.sv
rtl/mgmt_engine.sv
rtl/multicast_group_membership_table_core.sv
tb/sv/tb_multicast_group_membership_table_core.sv
